// ===== rtl/core/fcs_pkg.sv =====
// Shared types and constants for the frame checksum and sequence checker.
// No dependencies.
package fcs_pkg;

    localparam int unsigned ADDR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_LAST   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_HIGH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LOW  = 8'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SUM_ERR   = 2'd1,
        ST_COUNT_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] byte_value;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        t_status            frame_status;
        logic [COUNT_W-1:0] frame_count;
        logic [BYTE_W-1:0]  computed_sum;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] sum_last_address;
        logic [ADDR_W-1:0] checksum_address;
        logic [ADDR_W-1:0] count_high_address;
        logic [ADDR_W-1:0] count_low_address;
    } t_cfg;

endpackage

// ===== rtl/core/fcs_cfg_regs.sv =====
// Configuration register file for the frame checker.
// Depends on fcs_pkg.
module fcs_cfg_regs
    import fcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sum_last_address   <= 8'd255;
            r_cfg.checksum_address   <= '0;
            r_cfg.count_high_address <= '0;
            r_cfg.count_low_address  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SUM_LAST:   r_cfg.sum_last_address   <= i_cfg_data;
                CFG_CHECKSUM:   r_cfg.checksum_address   <= i_cfg_data;
                CFG_COUNT_HIGH: r_cfg.count_high_address <= i_cfg_data;
                CFG_COUNT_LOW:  r_cfg.count_low_address  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fcs_check.sv =====
// Frame state (running sum, captured bytes, previous count) and status logic.
// Depends on fcs_pkg.
module fcs_check
    import fcs_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    input  logic      i_advance,
    output t_out_item o_result
);

    localparam logic [ADDR_W:0] FRAME_LIMIT = (ADDR_W+1)'(FRAME_BYTES);

    logic [BYTE_W-1:0]  r_running_sum;
    logic [BYTE_W-1:0]  r_rx_checksum;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_prev_count;

    logic               in_range;
    logic               sum_hit;
    logic [BYTE_W-1:0]  n_running_sum;
    logic [BYTE_W-1:0]  n_rx_checksum;
    logic [COUNT_W-1:0] n_count;
    t_status            status;

    always_comb begin
        in_range = {1'b0, i_item.byte_address} < FRAME_LIMIT;
        sum_hit  = in_range && (i_item.byte_address != '0)
                   && (i_item.byte_address <= i_cfg.sum_last_address);

        n_running_sum = sum_hit ? r_running_sum + i_item.byte_value : r_running_sum;

        n_rx_checksum = r_rx_checksum;
        if (in_range && i_item.byte_address == i_cfg.checksum_address) begin
            n_rx_checksum = i_item.byte_value;
        end

        // when both count addresses match, the byte fills both halves
        n_count = r_count;
        if (in_range && i_item.byte_address == i_cfg.count_high_address) begin
            n_count[COUNT_W-1:BYTE_W] = i_item.byte_value;
        end
        if (in_range && i_item.byte_address == i_cfg.count_low_address) begin
            n_count[BYTE_W-1:0] = i_item.byte_value;
        end

        if (n_running_sum != n_rx_checksum) begin
            status = ST_SUM_ERR;
        end else if ((n_count > r_prev_count)
                     || (n_count == '0 && r_prev_count == COUNT_MAX)) begin
            status = ST_OK;
        end else begin
            status = ST_COUNT_ERR;
        end

        o_result.frame_status = status;
        o_result.frame_count  = n_count;
        o_result.computed_sum = n_running_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= '0;
            r_rx_checksum <= '0;
            r_count       <= '0;
            r_prev_count  <= '0;
        end else if (i_advance) begin
            r_running_sum <= i_item.frame_end ? '0 : n_running_sum;
            r_rx_checksum <= n_rx_checksum;
            r_count       <= n_count;
            // a checksum failure keeps the old count
            if (i_item.frame_end && status != ST_SUM_ERR) begin
                r_prev_count <= n_count;
            end
        end
    end

endmodule

// ===== rtl/core/frame_checksum_sequence_checker.sv =====
// Top level of the frame checksum and refresh sequence checker.
// Depends on fcs_pkg, fcs_cfg_regs and fcs_check.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one frame byte per
//   request with its address and an end-of-frame mark. Output channel
//   (o_out_valid / i_out_stall / o_out) carries one status request per frame,
//   issued for the byte marked frame_end. Configuration channel (i_cfg_valid /
//   o_cfg_ready) is always ready and writes the four address registers; the
//   user must write it only while the block is idle; this is not enforced.
// Timing:
//   One byte per cycle sustained while no final byte is held. A byte is
//   registered on acceptance and evaluated in the next cycle by an 8-bit add
//   and 16-bit compare; the status is registered when the final byte leaves
//   the input register, and a stalled output can hold it there.
// Reset:
//   Synchronous, active low. Clears pipeline valids, frame state and the
//   previous count; address registers return to their defaults.
// Stall:
//   Non-final bytes keep flowing while a status waits. A final byte waits in
//   the input register until the output register frees, and o_in_stall is
//   high for as long as it waits.
module frame_checksum_sequence_checker
    import fcs_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_free;
    logic      s1_advance;
    logic      in_accept;

    fcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    fcs_check #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_item    (r_s1),
        .i_advance (s1_advance),
        .o_result  (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && (!r_s1.frame_end || out_free);
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1.frame_end) begin
            r_out <= result;
        end
    end

    // stall only ever comes from a held final byte
    a_stall_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1.frame_end && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked final byte");

    // a final byte that leaves the input register always yields a status
    a_final_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1.frame_end) |=> r_out_valid)
        else $error("final byte consumed without a status");

    // a status only appears after a final byte moved on
    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(s1_advance && r_s1.frame_end))
        else $error("status issued without a final byte");

endmodule
